FILE: hw/rtl/lpmd_pkg.sv
// lpmd_pkg: types and constants for the length-prefixed message deframer
// no dependencies; imported by length_prefixed_message_deframer_unit
`default_nettype none

package lpmd_pkg;

  // channels with their own deframing state
  localparam int CHANNELS = 16;
  localparam int CHAN_W   = $clog2(CHANNELS);

  // bytes of one size word in the header
  localparam int WORD_BYTES = 4;
  // header position of the byte order marker
  localparam int MARK_POS   = 2 * WORD_BYTES;
  // total header length, marker included
  localparam int HEADER_LEN = MARK_POS + 1;

  // input item kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // configuration register indexes
  localparam logic REG_SIZE_MARKER = 1'b0;
  localparam logic REG_NATIVE_BE   = 1'b1;

  localparam logic [7:0] SIZE_MARKER_RST = 8'd36;

  typedef struct packed {
    logic       kind;
    logic [3:0] channel;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [7:0]  out_byte;
    logic        first_of_message;
    logic        last_of_message;
    logic        size_error;
    logic [31:0] message_length;
  } out_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] dsize;
  } chan_state_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/length_prefixed_message_deframer_unit.sv
// length_prefixed_message_deframer_unit: per-channel deframer top level
// depends on lpmd_pkg
`default_nettype none

// Takes one byte beat per cycle unless the output stalls, tagged with a
// channel, and passes every data byte through with first and last marks. The
// first nine bytes of a message are its header: two 32-bit size words and a
// marker byte. If the marker equals size_marker the second word is taken
// big-endian, else the first word in the order native_big_endian selects. The
// size counts the whole message; a size below the header length ends the
// message at its marker byte with size_error set, and message_length carries
// the size on the last byte. A reset beat clears its channel and produces no
// output. Throughput is one beat per cycle on any mix of channels unless the
// output stalls; a beat passes from the input register, which feeds a
// read-modify-write of the channel's state (position, size words, decoded
// size) held in a 16-entry register file, into the output register. Repeated
// beats on one channel need no bypass because state is written in the same
// cycle the beat leaves the input register.
module length_prefixed_message_deframer_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire lpmd_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output lpmd_pkg::out_t      out_data_o,
  input  wire                 cfg_we_i,
  input  wire                 cfg_idx_i,
  input  wire  [7:0]          cfg_data_i
);
  import lpmd_pkg::*;

  // configuration
  logic [7:0] size_marker_q;
  logic       native_be_q;

  // input register
  logic  s1_valid_q;
  in_t   s1_q;

  // output register
  logic  out_valid_q;
  out_t  out_q;

  // per-channel state
  chan_state_t chan_q [CHANNELS];

  logic              chan_ok;
  logic              has_res;
  logic              out_free;
  logic              s1_fire;
  logic [CHAN_W-1:0] ch_idx;
  chan_state_t       st;
  chan_state_t       st_d;
  logic [31:0]       w1_n, w2_n, dsize_n;
  logic [32:0]       pos1;
  logic              first_b, last_b, err_b;
  out_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_marker_q <= SIZE_MARKER_RST;
      native_be_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SIZE_MARKER: size_marker_q <= cfg_data_i;
        REG_NATIVE_BE:   native_be_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves whenever its beat can be retired
  assign chan_ok    = ({28'd0, s1_q.channel} < 32'(CHANNELS));
  assign has_res    = (s1_q.kind == KIND_DATA) && chan_ok;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!has_res || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  // channel state lookup and header decode
  assign ch_idx = s1_q.channel[CHAN_W-1:0];
  assign st     = chan_q[ch_idx];
  assign pos1   = {1'b0, st.pos} + 33'd1;

  always_comb begin
    w1_n    = st.word1;
    w2_n    = st.word2;
    dsize_n = st.dsize;
    // size words gather most significant byte first
    if (st.pos < 32'(WORD_BYTES)) begin
      w1_n = {st.word1[23:0], s1_q.data_byte};
    end else if (st.pos < 32'(2 * WORD_BYTES)) begin
      w2_n = {st.word2[23:0], s1_q.data_byte};
    end else if (st.pos == 32'(MARK_POS)) begin
      if (s1_q.data_byte == size_marker_q) begin
        dsize_n = st.word2;
      end else if (native_be_q) begin
        dsize_n = st.word1;
      end else begin
        dsize_n = swap32(st.word1);
      end
    end
  end

  always_comb begin
    first_b = (st.pos == 32'd0);
    last_b  = 1'b0;
    err_b   = 1'b0;
    if (pos1 == 33'(HEADER_LEN)) begin
      // marker byte: a short size closes the message here
      if (dsize_n < 32'(HEADER_LEN)) begin
        last_b = 1'b1;
        err_b  = 1'b1;
      end else if (dsize_n == 32'(HEADER_LEN)) begin
        last_b = 1'b1;
      end
    end else if (pos1 > 33'(HEADER_LEN) && pos1 >= {1'b0, dsize_n}) begin
      last_b = 1'b1;
    end
  end

  always_comb begin
    if (last_b) begin
      st_d = '0;
    end else begin
      st_d = '{pos: pos1[31:0], word1: w1_n, word2: w2_n, dsize: dsize_n};
    end
  end

  assign res = '{out_channel:      s1_q.channel,
                 out_byte:         s1_q.data_byte,
                 first_of_message: first_b,
                 last_of_message:  last_b,
                 size_error:       err_b,
                 message_length:   last_b ? dsize_n : 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_q[i] <= '0;
      end
    end else if (s1_fire && chan_ok) begin
      if (s1_q.kind == KIND_RESET) begin
        chan_q[ch_idx] <= '0;
      end else begin
        chan_q[ch_idx] <= st_d;
      end
    end
  end

  // output register, refilled in the cycle it drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // an empty input register always takes a beat
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

  // a retired data beat always shows up at the output
  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && has_res) |=> out_valid_q)
    else $error("data beat lost between stages");

  // an error only closes a message with a short size
  a_err_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.size_error) |->
      (out_q.last_of_message && out_q.message_length < 32'(HEADER_LEN)))
    else $error("size error on a well-sized or open message");
`endif

endmodule

`default_nettype wire
